@@ hw/rtl/asob_pkg.sv @@
// asob_pkg: shared types and constants of the alpha sprite overlay blend.
// No dependencies; every other file of the block imports it.
package asob_pkg;

  localparam int CHAN_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int ROW_W      = 12;
  localparam int NUM_CHAN   = 3;

  // sprite and line size limits; address and counter widths are built around them
  localparam int MAX_SPRITE_WIDTH  = 256;
  localparam int MAX_SPRITE_HEIGHT = 256;
  localparam int MAX_LINE_WIDTH    = 4096;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BG_WIDTH      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOC_X         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOC_Y         = 3'd4;

  // reset values of the configuration registers
  localparam logic [12:0] RST_BG_WIDTH      = 13'd640;
  localparam logic [8:0]  RST_SPRITE_WIDTH  = 9'd256;
  localparam logic [8:0]  RST_SPRITE_HEIGHT = 9'd256;
  localparam logic [12:0] RST_LOC           = 13'd0;

  // input command codes
  localparam logic CMD_SPRITE_WR = 1'b0;
  localparam logic CMD_BG_PIXEL  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic        first_of_frame;
    logic [15:0] sprite_addr;
    chan_t       chan0;
    chan_t       chan1;
    chan_t       chan2;
    chan_t       alpha;
  } in_word_t;

  typedef struct packed {
    chan_t out_chan0;
    chan_t out_chan1;
    chan_t out_chan2;
    logic  inside_sprite;
  } out_word_t;

  // stage enables of the blend pipeline
  typedef struct packed {
    logic en_prod;
    logic en_div;
  } mix_ctl_t;

endpackage

@@ hw/rtl/asob_if.sv @@
// asob_if: valid/ready channel interfaces for input and result words.
// Depends on asob_pkg for the payload structs.
interface asob_in_if import asob_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface asob_out_if import asob_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/alpha_sprite_overlay_blend.sv @@
// alpha_sprite_overlay_blend: top level, sprite memory, raster counters and pipeline.
// Depends on asob_pkg, asob_if and asob_mix.
//
// Takes one word per clock while the result channel is not stalled, sprite writes
// and background pixels alike, and returns one composited pixel per background
// word through the registered sprite-memory read, the registered channel products
// and the registered divide by 255. Throughput is set by the single-port sprite
// memory, which each word uses once (a write or a read), so the rate is one word
// per cycle with no interlock beyond output back-pressure. Sprite memory holds no
// reset contents and needs no clearing pass; only entries already written may be
// blended. A write goes straight to memory and is visible to the next word.
module alpha_sprite_overlay_blend import asob_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  asob_in_if.sink               in_ch,
  asob_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = MAX_SPRITE_WIDTH * MAX_SPRITE_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int FXW   = $clog2(MAX_SPRITE_WIDTH);
  localparam int FYW   = $clog2(MAX_SPRITE_HEIGHT);
  localparam int XW    = $clog2(MAX_LINE_WIDTH);
  localparam int BW_W  = $clog2(MAX_LINE_WIDTH + 1);
  localparam int SW_W  = $clog2(MAX_SPRITE_WIDTH + 1);
  localparam int SH_W  = $clog2(MAX_SPRITE_HEIGHT + 1);
  localparam int PW    = ((XW > 13) ? XW : 13) + 2;

  // configuration
  logic [12:0] bg_width_r, bg_width_nxt;
  logic [8:0]  sprite_width_r, sprite_width_nxt;
  logic [8:0]  sprite_height_r, sprite_height_nxt;
  logic [12:0] loc_x_r, loc_x_nxt;
  logic [12:0] loc_y_r, loc_y_nxt;

  // raster position
  logic [XW-1:0]    raster_x_r, raster_x_nxt;
  logic [ROW_W-1:0] raster_y_r, raster_y_nxt;
  logic [XW-1:0]    cur_x;
  logic [ROW_W-1:0] cur_y;
  logic [XW:0]      x_inc;
  logic             wrap;

  logic [BW_W-1:0]      bw;
  logic [SW_W-1:0]      sw;
  logic [SH_W-1:0]      sh;
  logic signed [PW-1:0] fx, fy;
  logic                 in_window;

  // pipeline control
  logic acc, acc_bg, en1, en2, en3;
  logic v1_r, v2_r, v3_r;
  mix_ctl_t mix_ctl;

  // sprite memory
  logic [31:0]   mem [DEPTH];
  logic          mem_we, mem_re, wr_ok;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rd_word_r;

  // stage 1 payload
  rgb_t  bg1_r;
  logic  inside1_r;
  rgb_t  fg1, res;
  chan_t alpha1;
  logic  inside_res;

  // ---------------- configuration ----------------
  always_comb begin
    bg_width_nxt      = bg_width_r;
    sprite_width_nxt  = sprite_width_r;
    sprite_height_nxt = sprite_height_r;
    loc_x_nxt         = loc_x_r;
    loc_y_nxt         = loc_y_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BG_WIDTH:      bg_width_nxt      = cfg_data;
        CFG_SPRITE_WIDTH:  sprite_width_nxt  = cfg_data[8:0];
        CFG_SPRITE_HEIGHT: sprite_height_nxt = cfg_data[8:0];
        CFG_LOC_X:         loc_x_nxt         = cfg_data;
        CFG_LOC_Y:         loc_y_nxt         = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bg_width_r      <= RST_BG_WIDTH;
      sprite_width_r  <= RST_SPRITE_WIDTH;
      sprite_height_r <= RST_SPRITE_HEIGHT;
      loc_x_r         <= RST_LOC;
      loc_y_r         <= RST_LOC;
    end else begin
      bg_width_r      <= bg_width_nxt;
      sprite_width_r  <= sprite_width_nxt;
      sprite_height_r <= sprite_height_nxt;
      loc_x_r         <= loc_x_nxt;
      loc_y_r         <= loc_y_nxt;
    end
  end

  // ---------------- handshake and stage enables ----------------
  assign en3          = !v3_r || out_ch.ready;
  assign en2          = !v2_r || en3;
  assign en1          = !v1_r || en2;
  assign in_ch.ready  = en1;
  assign acc          = in_ch.valid && en1;
  assign acc_bg       = acc && (in_ch.data.cmd == CMD_BG_PIXEL);
  assign mix_ctl.en_prod = en2;
  assign mix_ctl.en_div  = en3;

  // ---------------- window test and raster counters ----------------
  always_comb begin
    bw = (bg_width_r == '0) ? BW_W'(1) :
         ((32'(bg_width_r) > MAX_LINE_WIDTH) ? BW_W'(MAX_LINE_WIDTH) : BW_W'(bg_width_r));
    sw = (32'(sprite_width_r) > MAX_SPRITE_WIDTH) ?
         SW_W'(MAX_SPRITE_WIDTH) : SW_W'(sprite_width_r);
    sh = (32'(sprite_height_r) > MAX_SPRITE_HEIGHT) ?
         SH_W'(MAX_SPRITE_HEIGHT) : SH_W'(sprite_height_r);

    cur_x = in_ch.data.first_of_frame ? '0 : raster_x_r;
    cur_y = in_ch.data.first_of_frame ? '0 : raster_y_r;

    fx = $signed(PW'(cur_x)) - PW'($signed(loc_x_r));
    fy = $signed(PW'(cur_y)) - PW'($signed(loc_y_r));
    in_window = !fx[PW-1] && !fy[PW-1] &&
                ($unsigned(fx) < PW'(sw)) && ($unsigned(fy) < PW'(sh));

    x_inc = {1'b0, cur_x} + 1'b1;
    wrap  = 32'(x_inc) >= 32'(bw);
    raster_x_nxt = raster_x_r;
    raster_y_nxt = raster_y_r;
    if (acc_bg) begin
      raster_x_nxt = wrap ? '0 : x_inc[XW-1:0];
      raster_y_nxt = wrap ? cur_y + 1'b1 : cur_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raster_x_r <= '0;
      raster_y_r <= '0;
    end else begin
      raster_x_r <= raster_x_nxt;
      raster_y_r <= raster_y_nxt;
    end
  end

  // ---------------- sprite memory ----------------
  assign wr_ok  = 32'(in_ch.data.sprite_addr) < 32'(DEPTH);
  assign mem_we = acc && (in_ch.data.cmd == CMD_SPRITE_WR) && wr_ok;
  assign mem_re = acc_bg;
  assign waddr  = AW'(in_ch.data.sprite_addr);
  assign wdata  = {in_ch.data.alpha, in_ch.data.chan2, in_ch.data.chan1, in_ch.data.chan0};
  assign raddr  = AW'(fy[FYW-1:0]) * AW'(MAX_SPRITE_WIDTH) + AW'(fx[FXW-1:0]);

  // one access per word, so a write and a read never share a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_word_r <= mem[raddr];
    end
  end

  // ---------------- stage 1 ----------------
  always_ff @(posedge clk) begin
    if (en1) begin
      bg1_r     <= {in_ch.data.chan2, in_ch.data.chan1, in_ch.data.chan0};
      inside1_r <= in_window;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= acc_bg;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  assign fg1    = rd_word_r[23:0];
  assign alpha1 = rd_word_r[31:24];

  asob_mix u_mix (
    .clk      (clk),
    .ctl      (mix_ctl),
    .inside_i (inside1_r),
    .bg_i     (bg1_r),
    .fg_i     (fg1),
    .alpha_i  (alpha1),
    .res_o    (res),
    .inside_o (inside_res)
  );

  // ---------------- result word ----------------
  assign out_ch.valid = v3_r;
  always_comb begin
    out_ch.data.out_chan0     = res[0];
    out_ch.data.out_chan1     = res[1];
    out_ch.data.out_chan2     = res[2];
    out_ch.data.inside_sprite = inside_res;
  end

`ifndef SYNTH
  // a sprite write never enters the result pipeline
  a_wr_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_ch.data.cmd == CMD_SPRITE_WR)) |=> !v1_r)
    else $error("sprite write produced a pipeline word");

  // start of frame restarts the raster at column one of row zero
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_bg && in_ch.data.first_of_frame && (bw > BW_W'(1)) && !cfg_we)
    |=> (raster_x_r == XW'(1)) && (raster_y_r == '0))
    else $error("raster counters did not restart on first pixel of frame");

  // a waiting result only leaves through a handshake
  a_out_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(v3_r) |-> $past(out_ch.ready))
    else $error("result word dropped");

  // an empty first stage always takes a word
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_ch.ready)
    else $error("input stalled with an empty first stage");

  // the sprite memory is never read and written in the same cycle
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("sprite memory read and write collided");
`endif

endmodule

@@ hw/rtl/asob_mix.sv @@
// asob_mix: two-stage per-channel blend, products then exact divide by 255.
// Depends on asob_pkg; stage enables come from the top level.
module asob_mix import asob_pkg::*; (
  input  logic     clk,
  input  mix_ctl_t ctl,
  input  logic     inside_i,
  input  rgb_t     bg_i,
  input  rgb_t     fg_i,
  input  chan_t    alpha_i,
  output rgb_t     res_o,
  output logic     inside_o
);

  logic [NUM_CHAN-1:0][15:0] sum_nxt, sum_r;
  logic                      inside_a_r;
  rgb_t                      res_nxt, res_r;
  logic                      inside_b_r;
  chan_t                     a_eff;
  rgb_t                      fg_eff;
  logic [16:0]               t;

  // outside the window alpha is forced to zero so bg*255/255 passes bg through
  always_comb begin
    a_eff  = inside_i ? alpha_i : '0;
    fg_eff = inside_i ? fg_i : '0;
    for (int i = 0; i < NUM_CHAN; i++) begin
      sum_nxt[i] = 16'(bg_i[i]) * 16'(8'd255 - a_eff) + 16'(fg_eff[i]) * 16'(a_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_prod) begin
      sum_r      <= sum_nxt;
      inside_a_r <= inside_i;
    end
  end

  // floor(s/255) = (s + 1 + (s >> 8)) >> 8 for s up to 255*255
  always_comb begin
    t = '0;
    for (int i = 0; i < NUM_CHAN; i++) begin
      t          = 17'(sum_r[i]) + 17'(sum_r[i][15:8]) + 17'd1;
      res_nxt[i] = t[15:8];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_div) begin
      res_r      <= res_nxt;
      inside_b_r <= inside_a_r;
    end
  end

  assign res_o    = res_r;
  assign inside_o = inside_b_r;

endmodule

@@ test/asob_blend_checker.sv @@
// asob_blend_checker: watches the word channels and config port of the overlay blend,
// predicts each composited pixel and compares it with what the block returns.
// Depends on asob_pkg and the channel interfaces in asob_if.
module asob_blend_checker import asob_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  asob_in_if                    in_mon,
  asob_out_if                   out_mon,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    n_writes,
  output int                    n_pixels,
  output int                    n_blended
);

  localparam int SPRITE_PITCH = 256;
  localparam int SPRITE_ROWS  = 256;
  localparam int LINE_MAX     = 4096;
  localparam int SHOW_MAX     = 20;

  logic [31:0]        sprite_store [0:SPRITE_PITCH*SPRITE_ROWS-1];
  logic [ROW_W-1:0]   pos_x;
  logic [ROW_W-1:0]   pos_y;
  logic [12:0]        bg_width_r;
  logic [8:0]         spr_w_r;
  logic [8:0]         spr_h_r;
  logic signed [12:0] loc_x_r;
  logic signed [12:0] loc_y_r;

  out_word_t expected_pixels [$];
  int        result_idx;

  function automatic chan_t blend_chan(chan_t bg, chan_t fg, chan_t a);
    int acc;
    acc = int'(bg) * (255 - int'(a)) + int'(fg) * int'(a);
    return chan_t'(acc / 255);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= SHOW_MAX)
      $display("mismatch on result %0d at %0t: %s got %0d want %0d",
               result_idx, $time, what, got, want);
  endtask

  // places one background pixel on the raster, blends it if it hits the window
  task automatic composite_pixel(input in_word_t w, output out_word_t r);
    int          sw;
    int          sh;
    int          bw;
    int          fx;
    int          fy;
    logic [31:0] spr;
    if (w.first_of_frame) begin
      pos_x = '0;
      pos_y = '0;
    end
    sw = (int'(spr_w_r) > SPRITE_PITCH) ? SPRITE_PITCH : int'(spr_w_r);
    sh = (int'(spr_h_r) > SPRITE_ROWS) ? SPRITE_ROWS : int'(spr_h_r);
    fx = int'(pos_x) - int'(loc_x_r);
    fy = int'(pos_y) - int'(loc_y_r);
    if (fx >= 0 && fy >= 0 && fx < sw && fy < sh) begin
      spr = sprite_store[fy * SPRITE_PITCH + fx];
      r.out_chan0     = blend_chan(w.chan0, spr[7:0], spr[31:24]);
      r.out_chan1     = blend_chan(w.chan1, spr[15:8], spr[31:24]);
      r.out_chan2     = blend_chan(w.chan2, spr[23:16], spr[31:24]);
      r.inside_sprite = 1'b1;
    end else begin
      r.out_chan0     = w.chan0;
      r.out_chan1     = w.chan1;
      r.out_chan2     = w.chan2;
      r.inside_sprite = 1'b0;
    end
    // width 0 acts as 1, anything past the line maximum saturates
    bw = (bg_width_r == '0) ? 1 : ((int'(bg_width_r) > LINE_MAX) ? LINE_MAX : int'(bg_width_r));
    if (int'(pos_x) + 1 >= bw) begin
      pos_x = '0;
      pos_y = pos_y + 1'b1;
    end else begin
      pos_x = pos_x + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    if (!rst_n) begin
      pos_x      = '0;
      pos_y      = '0;
      bg_width_r = RST_BG_WIDTH;
      spr_w_r    = RST_SPRITE_WIDTH;
      spr_h_r    = RST_SPRITE_HEIGHT;
      loc_x_r    = RST_LOC;
      loc_y_r    = RST_LOC;
      expected_pixels.delete();
      fail_count = 0;
      n_writes   = 0;
      n_pixels   = 0;
      n_blended  = 0;
      result_idx = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BG_WIDTH:      bg_width_r = cfg_data[12:0];
          CFG_SPRITE_WIDTH:  spr_w_r    = cfg_data[8:0];
          CFG_SPRITE_HEIGHT: spr_h_r    = cfg_data[8:0];
          CFG_LOC_X:         loc_x_r    = cfg_data[12:0];
          CFG_LOC_Y:         loc_y_r    = cfg_data[12:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.data.cmd == CMD_SPRITE_WR) begin
          sprite_store[in_mon.data.sprite_addr] = {in_mon.data.alpha, in_mon.data.chan2,
                                                   in_mon.data.chan1, in_mon.data.chan0};
          n_writes++;
        end else begin
          composite_pixel(in_mon.data, want);
          expected_pixels = {expected_pixels, want};
          n_pixels++;
          if (want.inside_sprite) n_blended++;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (expected_pixels.size() == 0) begin
          flag_mismatch("result word with none expected", int'(got.out_chan0), -1);
        end else begin
          want = expected_pixels.pop_front();
          if (got.out_chan0 !== want.out_chan0)
            flag_mismatch("out_chan0", int'(got.out_chan0), int'(want.out_chan0));
          if (got.out_chan1 !== want.out_chan1)
            flag_mismatch("out_chan1", int'(got.out_chan1), int'(want.out_chan1));
          if (got.out_chan2 !== want.out_chan2)
            flag_mismatch("out_chan2", int'(got.out_chan2), int'(want.out_chan2));
          if (got.inside_sprite !== want.inside_sprite)
            flag_mismatch("inside_sprite", int'(got.inside_sprite), int'(want.inside_sprite));
        end
        result_idx++;
      end
    end
    pending = expected_pixels.size();
  end

endmodule

@@ test/tb_top.sv @@
// tb_top: stimulus and verdict for alpha_sprite_overlay_blend; the checker does the
// prediction. Depends on asob_pkg, asob_if, the block and asob_blend_checker.
module tb_top;
  import asob_pkg::*;

  localparam int CYCLE_LIMIT    = 600000;
  localparam int RESULT_LATENCY = 3;
  localparam int SPRITE_PITCH   = 256;
  localparam int SPRITE_ROWS    = 256;
  localparam int LINE_MAX       = 4096;
  localparam int STALL_CYCLES   = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int send_idle_pct;
  int recv_idle_pct;
  bit stall_go;
  bit stall_done;
  int stall_left;
  int cycle_count;

  int fail_count;
  int pending;
  int n_writes;
  int n_pixels;
  int n_blended;

  // stimulus-side view of the raster, so no unwritten sprite entry gets blended
  bit written_map [0:SPRITE_PITCH*SPRITE_ROWS-1];
  int cur_bw;
  int cur_sw;
  int cur_sh;
  int cur_lx;
  int cur_ly;
  int scan_x;
  int scan_y;

  asob_in_if  in_ch();
  asob_out_if out_ch();

  alpha_sprite_overlay_blend dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  asob_blend_checker blend_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .n_writes   (n_writes),
    .n_pixels   (n_pixels),
    .n_blended  (n_blended)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver: random stalls plus one long hold-off when asked
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (stall_go && !stall_done) begin
        stall_done = 1'b1;
        stall_left = STALL_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic chan_t pick_level();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  function automatic int window_addr();
    int fx;
    int fy;
    fx = scan_x - cur_lx;
    fy = scan_y - cur_ly;
    if (fx < 0 || fy < 0 || fx >= cur_sw || fy >= cur_sh) return -1;
    return fy * SPRITE_PITCH + fx;
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic put_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic put_sprite(input int addr, input chan_t c0, input chan_t c1,
                            input chan_t c2, input chan_t a, input bit first);
    in_word_t w;
    w.cmd            = CMD_SPRITE_WR;
    w.first_of_frame = first;
    w.sprite_addr    = 16'(addr);
    w.chan0          = c0;
    w.chan1          = c1;
    w.chan2          = c2;
    w.alpha          = a;
    put_word(w);
    written_map[addr] = 1'b1;
  endtask

  task automatic send_pixel(input bit first, input chan_t c0, input chan_t c1, input chan_t c2);
    in_word_t w;
    int       hit;
    if (first) begin
      scan_x = 0;
      scan_y = 0;
    end
    hit = window_addr();
    if (hit >= 0 && !written_map[hit])
      put_sprite(hit, pick_level(), pick_level(), pick_level(), pick_level(),
                 1'($urandom_range(1)));
    w.cmd            = CMD_BG_PIXEL;
    w.first_of_frame = first;
    w.sprite_addr    = 16'($urandom_range(65535));
    w.chan0          = c0;
    w.chan1          = c1;
    w.chan2          = c2;
    w.alpha          = chan_t'($urandom_range(255));
    put_word(w);
    scan_x++;
    if (scan_x >= cur_bw) begin
      scan_x = 0;
      scan_y = (scan_y + 1) % 4096;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (RESULT_LATENCY + 2) @(negedge clk);
  endtask

  // registers change only with the pipeline empty
  task automatic reconfigure(input int bw, input int sw, input int sh, input int lx, input int ly);
    drain_and_settle();
    write_reg(CFG_BG_WIDTH, bw);
    write_reg(CFG_SPRITE_WIDTH, sw);
    write_reg(CFG_SPRITE_HEIGHT, sh);
    write_reg(CFG_LOC_X, lx);
    write_reg(CFG_LOC_Y, ly);
    cfg_we <= 1'b0;
    @(negedge clk);
    cur_bw = (bw < 1) ? 1 : ((bw > LINE_MAX) ? LINE_MAX : bw);
    cur_sw = (sw > SPRITE_PITCH) ? SPRITE_PITCH : sw;
    cur_sh = (sh > SPRITE_ROWS) ? SPRITE_ROWS : sh;
    cur_lx = lx;
    cur_ly = ly;
  endtask

  task automatic pump_items(input int n, input int write_pct, input int first_pct);
    int addr;
    for (int i = 0; i < n; i++) begin
      if (i != 0 && $urandom_range(99) < write_pct) begin
        // mostly hit the live window so blends see fresh sprite data
        if (cur_sw > 0 && cur_sh > 0 && $urandom_range(99) < 70)
          addr = int'($urandom_range(cur_sh - 1)) * SPRITE_PITCH
               + int'($urandom_range(cur_sw - 1));
        else
          addr = int'($urandom_range(65535));
        put_sprite(addr, pick_level(), pick_level(), pick_level(), pick_level(),
                   1'($urandom_range(1)));
      end else begin
        send_pixel(i == 0 || $urandom_range(99) < first_pct,
                   pick_level(), pick_level(), pick_level());
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    stall_go      = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 70;
    cur_bw        = int'(RST_BG_WIDTH);
    cur_sw        = int'(RST_SPRITE_WIDTH);
    cur_sh        = int'(RST_SPRITE_HEIGHT);
    cur_lx        = 0;
    cur_ly        = 0;
    scan_x        = 0;
    scan_y        = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset config: opaque, clear and half alpha, extreme address, ignored frame flag
    put_sprite(0, 8'hff, 8'h00, 8'h80, 8'hff, 1'b1);
    put_sprite(1, 8'h12, 8'h34, 8'h56, 8'h00, 1'b0);
    put_sprite(2, 8'hff, 8'hff, 8'hff, 8'h80, 1'b0);
    put_sprite(65535, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    send_pixel(1'b1, 8'h00, 8'hff, 8'h7f);
    send_pixel(1'b0, 8'hff, 8'h00, 8'h55);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00);
    // empty window, zero line width, far corners of the position range
    reconfigure(0, 0, 300, -4096, 4095);
    send_pixel(1'b1, 8'hff, 8'hff, 8'hff);
    send_pixel(1'b0, 8'h01, 8'h80, 8'hfe);
    // oversized register values, window hanging off the left edge
    reconfigure(8191, 511, 1, -1, 0);
    send_pixel(1'b1, 8'hff, 8'hff, 8'hff);
    send_pixel(1'b0, 8'h00, 8'h00, 8'h00);

    reconfigure(16, 5, 4, 3, 2);
    pump_items(150, 25, 2);
    reconfigure(7, 256, 256, -2, -3);
    pump_items(150, 25, 2);

    send_idle_pct = 70;
    recv_idle_pct = 34;
    reconfigure(3, 2, 300, 1, -250);
    pump_items(130, 20, 2);
    reconfigure(4096, 1, 1, 100, 0);
    pump_items(100, 20, 0);
    reconfigure(20, 8, 3, 15, 0);
    pump_items(130, 25, 3);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // long output hold-off while words keep coming, fills the pipe
    reconfigure(10, 6, 6, 2, 1);
    stall_go = 1'b1;
    pump_items(120, 20, 2);
    // zero line width: one pixel per row
    reconfigure(0, 1, 2, 0, 0);
    pump_items(40, 0, 0);
    // saturated line width with the window one row down
    reconfigure(8191, 3, 1, 0, 1);
    pump_items(40, 0, 0);
    reconfigure(int'(RST_BG_WIDTH), int'(RST_SPRITE_WIDTH), int'(RST_SPRITE_HEIGHT), 0, 0);
    pump_items(120, 30, 3);

    drain_and_settle();
    $display("covered %0d sprite writes and %0d background pixels, %0d blended",
             n_writes, n_pixels, n_blended);
    $display("window sizes 0 to 511, line widths 0 to 8191, line wrap, long stalls");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
